// ----- hdl/cwwb_pkg.sv -----
// ----------------------------------------------------------------------------
// cwwb_pkg
// Shared constants and payload types for the column weighted window blur.
// ----------------------------------------------------------------------------
package cwwb_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned DIV_W = 10;
    localparam logic [DIV_W-1:0] DIV_RESET = 10'd128;
    localparam logic [DIV_W-1:0] DIV_MIN = 10'd4;

    typedef struct packed {
        logic              new_column;
        logic [PIX_W-1:0]  pixel_red;
        logic [PIX_W-1:0]  pixel_green;
        logic [PIX_W-1:0]  pixel_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]  out_red;
        logic [PIX_W-1:0]  out_green;
        logic [PIX_W-1:0]  out_blue;
    } pixel_out_t;

endpackage

// ----- hdl/cwwb_in_if.sv -----
// ----------------------------------------------------------------------------
// cwwb_in_if
// Valid/ready channel carrying one input pixel.
// ----------------------------------------------------------------------------
interface cwwb_in_if;
    logic                valid;
    logic                ready;
    cwwb_pkg::pixel_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cwwb_out_if.sv -----
// ----------------------------------------------------------------------------
// cwwb_out_if
// Valid/ready channel carrying one blurred pixel.
// ----------------------------------------------------------------------------
interface cwwb_out_if;
    logic                 valid;
    logic                 ready;
    cwwb_pkg::pixel_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cwwb_divider.sv -----
// ----------------------------------------------------------------------------
// cwwb_divider
// Restoring divider, one quotient bit per cycle, numerator and divisor unsigned.
// ----------------------------------------------------------------------------
module cwwb_divider #(
    parameter int unsigned NUM_W = 23,
    parameter int unsigned DEN_W = 15,
    parameter int unsigned Q_W   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [Q_W-1:0]   quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = numer;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg[Q_W-1:0];
endmodule

// ----- hdl/column_weighted_window_blur.sv -----
// ----------------------------------------------------------------------------
// column_weighted_window_blur
// Sliding-window brightness-weighted average over a pixel column.
//
//   channel    dir   payload                                  transfer when
//   pix_in     in    new_column, pixel_red/green/blue         valid & ready
//   pix_out    out   out_red/green/blue                       valid & ready
//   cfg        in    weight_divisor (10 bits)                 cfg_we
//
// A filling pixel passes the 10-step weight divide, the ring read and the sum
// update before the next input transfer.
// On a full window the three 23-step quotient divides run in parallel after
// the update; their result is loaded for pix_out when all three are done, and
// the next pixel can transfer only once that result has been loaded.
// The ring memory has one port; the sequencer reads the oldest slot, then
// writes it. Reset clears sums, slot and fill count; the ring needs no clear.
// A held result stalls the block only when the next result is ready while the
// previous one still waits on pix_out.
// ----------------------------------------------------------------------------
module column_weighted_window_blur #(
    parameter int unsigned WINDOW = 96
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cwwb_in_if.sink                    pix_in,
    cwwb_out_if.source                 pix_out,
    input  logic                       cfg_we,
    input  logic [cwwb_pkg::DIV_W-1:0] cfg_data
);
    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = 23;
    localparam int unsigned WT_W   = 15;
    localparam int unsigned PW     = cwwb_pkg::PIX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WDIV,
        ST_READ,
        ST_UPDATE,
        ST_QDIV,
        ST_QWAIT,
        ST_HOLD
    } state_t;

    state_t state_reg;
    logic [cwwb_pkg::DIV_W-1:0] wdiv_reg;
    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [WT_W-1:0]  wt_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [FILL_W-1:0] fill_reg;
    cwwb_pkg::pixel_in_t px_reg;
    logic [PW-1:0] w_reg;
    logic out_valid_reg;
    cwwb_pkg::pixel_out_t out_reg;

    logic [4*PW-1:0] ring_mem [WINDOW];
    logic [4*PW-1:0] ring_rd_reg;
    logic            ring_we;

    logic [cwwb_pkg::DIV_W-1:0] div_eff;
    logic [PW+1:0] bright;
    logic wd_done, qr_done, qg_done, qb_done;
    logic [PW-1:0] wd_q, qr, qg, qb;
    logic wd_start, q_start;
    logic full;
    logic q_done;
    logic out_load;

    assign div_eff = (wdiv_reg < cwwb_pkg::DIV_MIN) ? cwwb_pkg::DIV_MIN : wdiv_reg;
    assign bright  = {2'b00, pix_in.data.pixel_red} + {2'b00, pix_in.data.pixel_green}
                   + {2'b00, pix_in.data.pixel_blue};
    assign wd_start = pix_in.valid && pix_in.ready;
    assign q_start  = (state_reg == ST_QDIV);
    assign full     = (fill_reg == FILL_W'(WINDOW));
    assign ring_we  = (state_reg == ST_UPDATE);
    assign q_done   = qr_done && qg_done && qb_done;
    assign out_load = ((state_reg == ST_QWAIT && q_done) || state_reg == ST_HOLD)
                    && (!out_valid_reg || pix_out.ready);

    cwwb_divider #(.NUM_W(PW + 2), .DEN_W(cwwb_pkg::DIV_W), .Q_W(PW)) u_wdiv (
        .clk(clk), .rst_n(rst_n), .start(wd_start), .numer(bright),
        .denom(div_eff), .done(wd_done), .quot(wd_q)
    );
    cwwb_divider #(.NUM_W(SUM_W), .DEN_W(WT_W), .Q_W(PW)) u_qr (
        .clk(clk), .rst_n(rst_n), .start(q_start), .numer(sum_r_reg),
        .denom(wt_reg), .done(qr_done), .quot(qr)
    );
    cwwb_divider #(.NUM_W(SUM_W), .DEN_W(WT_W), .Q_W(PW)) u_qg (
        .clk(clk), .rst_n(rst_n), .start(q_start), .numer(sum_g_reg),
        .denom(wt_reg), .done(qg_done), .quot(qg)
    );
    cwwb_divider #(.NUM_W(SUM_W), .DEN_W(WT_W), .Q_W(PW)) u_qb (
        .clk(clk), .rst_n(rst_n), .start(q_start), .numer(sum_b_reg),
        .denom(wt_reg), .done(qb_done), .quot(qb)
    );

    assign pix_in.ready  = (state_reg == ST_IDLE);
    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= {px_reg.pixel_red, px_reg.pixel_green,
                                   px_reg.pixel_blue, w_reg};
        end
        ring_rd_reg <= ring_mem[slot_reg];
    end

    logic [PW-1:0] old_r, old_g, old_b, old_w;
    logic [2*PW-1:0] add_r, add_g, add_b, sub_r, sub_g, sub_b;
    assign {old_r, old_g, old_b, old_w} = ring_rd_reg;
    assign add_r = px_reg.pixel_red * w_reg;
    assign add_g = px_reg.pixel_green * w_reg;
    assign add_b = px_reg.pixel_blue * w_reg;
    assign sub_r = full ? old_r * old_w : '0;
    assign sub_g = full ? old_g * old_w : '0;
    assign sub_b = full ? old_b * old_w : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wdiv_reg      <= cwwb_pkg::DIV_RESET;
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            wt_reg        <= WT_W'(1);
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wdiv_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.valid && pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (wd_start)
                    begin
                        state_reg <= ST_WDIV;
                        if (pix_in.data.new_column)
                        begin
                            sum_r_reg <= '0;
                            sum_g_reg <= '0;
                            sum_b_reg <= '0;
                            wt_reg    <= WT_W'(1);
                            slot_reg  <= '0;
                            fill_reg  <= '0;
                        end
                    end
                end
                ST_WDIV:
                begin
                    if (wd_done)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    sum_r_reg <= sum_r_reg - SUM_W'(sub_r) + SUM_W'(add_r);
                    sum_g_reg <= sum_g_reg - SUM_W'(sub_g) + SUM_W'(add_g);
                    sum_b_reg <= sum_b_reg - SUM_W'(sub_b) + SUM_W'(add_b);
                    wt_reg    <= wt_reg - (full ? WT_W'(old_w) : '0) + WT_W'(w_reg);
                    slot_reg  <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    if (!full)
                    begin
                        fill_reg  <= fill_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_QDIV;
                    end
                end
                ST_QDIV:
                begin
                    state_reg <= ST_QWAIT;
                end
                ST_QWAIT:
                begin
                    if (q_done)
                    begin
                        state_reg <= out_load ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wd_start)
        begin
            px_reg <= pix_in.data;
        end
        if (state_reg == ST_WDIV && wd_done)
        begin
            w_reg <= wd_q + 1'b1;
        end
        if (out_load)
        begin
            out_reg.out_red   <= qr;
            out_reg.out_green <= qg;
            out_reg.out_blue  <= qb;
        end
    end
endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the column weighted window blur against a built-in predictor of the
// weighted window sums, over directed pixel columns, divisor changes and
// long random columns, with random idle bursts on input and output.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIN = 96;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [cwwb_pkg::DIV_W-1:0] cfg_data;

    cwwb_in_if pix_in();
    cwwb_out_if pix_out();

    column_weighted_window_blur #(.WINDOW(WIN)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pix_in(pix_in),
        .pix_out(pix_out),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    logic [7:0] win_red [WIN];
    logic [7:0] win_green [WIN];
    logic [7:0] win_blue [WIN];
    logic [7:0] win_weight [WIN];
    logic [22:0] acc_red;
    logic [22:0] acc_green;
    logic [22:0] acc_blue;
    logic [14:0] weight_sum;
    int unsigned slot_ptr;
    int unsigned held_count;
    logic [cwwb_pkg::DIV_W-1:0] divisor_reg;

    cwwb_pkg::pixel_out_t blurred_q[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    bit sink_stall_en;
    bit source_gap_en;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic clear_window();
        acc_red = '0;
        acc_green = '0;
        acc_blue = '0;
        weight_sum = 15'd1;
        slot_ptr = 0;
        held_count = 0;
    endtask

    task automatic predict_blur(input cwwb_pkg::pixel_in_t px);
        int unsigned dv;
        logic [7:0] w;
        logic [7:0] ow;
        cwwb_pkg::pixel_out_t res;
        bit full;
        dv = (divisor_reg < cwwb_pkg::DIV_MIN) ? cwwb_pkg::DIV_MIN : divisor_reg;
        w = 8'((int'(px.pixel_red) + px.pixel_green + px.pixel_blue) / dv + 1);
        if (px.new_column)
            clear_window();
        full = (held_count >= WIN);
        if (full)
        begin
            ow = win_weight[slot_ptr];
            acc_red -= 23'(win_red[slot_ptr] * ow);
            acc_green -= 23'(win_green[slot_ptr] * ow);
            acc_blue -= 23'(win_blue[slot_ptr] * ow);
            weight_sum -= 15'(ow);
        end
        else
            held_count++;
        win_red[slot_ptr] = px.pixel_red;
        win_green[slot_ptr] = px.pixel_green;
        win_blue[slot_ptr] = px.pixel_blue;
        win_weight[slot_ptr] = w;
        acc_red += 23'(px.pixel_red * w);
        acc_green += 23'(px.pixel_green * w);
        acc_blue += 23'(px.pixel_blue * w);
        weight_sum += 15'(w);
        slot_ptr = (slot_ptr + 1 >= WIN) ? 0 : slot_ptr + 1;
        if (full)
        begin
            res.out_red = 8'(acc_red / weight_sum);
            res.out_green = 8'(acc_green / weight_sum);
            res.out_blue = 8'(acc_blue / weight_sum);
            blurred_q.push_back(res);
        end
    endtask

    task automatic send_pixel(input bit nc, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        cwwb_pkg::pixel_in_t px;
        px.new_column = nc;
        px.pixel_red = r;
        px.pixel_green = g;
        px.pixel_blue = b;
        if (source_gap_en && $urandom_range(0, 3) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= px;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        predict_blur(px);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n)
            send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_divisor(input logic [cwwb_pkg::DIV_W-1:0] v);
        pix_in.valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        divisor_reg = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (blurred_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected transfer: %h", pix_out.data);
                end
                else
                begin
                    if (pix_out.data !== blurred_q[0])
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %h actual %h",
                                     blurred_q[0], pix_out.data);
                    end
                    void'(blurred_q.pop_front());
                end
            end
            if ((pix_out.valid && pix_out.ready) || (pix_in.valid && pix_in.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (sink_stall_en && $urandom_range(0, 5) == 0)
                pix_out.ready <= 1'b0;
            else if (!sink_stall_en || $urandom_range(0, 2) != 0)
                pix_out.ready <= 1'b1;
        end
    end

    task automatic test_extremes();
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
        send_pixel(1'b0, 8'hAA, 8'h55, 8'hAA);
        send_pixel(1'b0, 8'h55, 8'hAA, 8'h55);
        send_random(WIN - 7);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b1, 8'd10, 8'd20, 8'd30);
        send_random(WIN + 3);
    endtask

    task automatic test_divisor_sweep();
        write_divisor(10'd0);
        send_random(20);
        write_divisor(10'd3);
        send_random(20);
        write_divisor(10'd1023);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_random(WIN + 10);
        write_divisor(10'd768);
        send_random(15);
        write_divisor(10'd4);
    endtask

    task automatic test_random_columns(input int unsigned n);
        repeat (n)
        begin
            if ($urandom_range(0, 150) == 0)
                send_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            else if ($urandom_range(0, 3) == 0)
                send_pixel(1'b0, 8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                           8'($urandom_range(200, 255)));
            else
                send_random(1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        pix_out.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        sink_stall_en = 1'b1;
        source_gap_en = 1'b1;
        divisor_reg = cwwb_pkg::DIV_RESET;
        clear_window();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_random(WIN + 4);
        test_extremes();
        test_divisor_sweep();
        test_random_columns(30);
        write_divisor(10'($urandom_range(4, 1023)));
        test_random_columns(20);
        sink_stall_en = 1'b0;
        source_gap_en = 1'b0;
        test_random_columns(20);
        pix_in.valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/cwwb_pkg.sv
hdl/cwwb_in_if.sv
hdl/cwwb_out_if.sv
hdl/cwwb_divider.sv
hdl/column_weighted_window_blur.sv
sim/testbench.sv
